[hw/rtl/gll_pkg.sv]
package gll_pkg;

    localparam int MAX_FILTERS_DEF = 64;

    localparam int MAG_W   = 24;
    localparam int VAR_W   = 32;
    localparam int SCALE_W = 24;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 7;
    localparam int PROD_W  = VAR_W + SCALE_W;       // scaled variance, Q12.44
    localparam int SQ_W    = 48;                    // squared difference bits in use
    localparam int QUOT_W  = 49;                    // quotient, capped at 2^48
    localparam int LOG_FRAC_BITS = 30;
    localparam int LOG_MAG_W     = 37;
    localparam int LN_ACC_W      = LOG_MAG_W + 28;

    localparam logic [32:0] LOG2_TWO_PI_Q30 = 33'd2847022290;
    localparam logic [27:0] LN2_Q28         = 28'd186065279;

    typedef enum logic [1:0] {
        REG_VARIANCE_SCALE = 2'd0,
        REG_VARIANCE_FLOOR = 2'd1
    } gll_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_SQR,
        ST_LOG,
        ST_LNMUL,
        ST_DIV,
        ST_ACC
    } gll_state_t;

endpackage

[hw/rtl/gll_div.sv]
module gll_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gll_pkg::PROD_W-1:0]   divisor,
    input  logic [gll_pkg::SQ_W-1:0]     dividend,
    output logic                         done,
    output logic [gll_pkg::QUOT_W-1:0]   quotient
);
    import gll_pkg::*;

    localparam int NUM_W   = SQ_W + 27;
    localparam int STEPS   = NUM_W;
    localparam int STEP_W  = $clog2(STEPS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  capped_reg, capped_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [PROD_W-1:0]     rem_reg, rem_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;

    logic [PROD_W:0]       rem_shift;
    logic                  qbit;
    logic [QUOT_W:0]       quot_shift;

    always_comb
    begin
        rem_shift  = {rem_reg, num_reg[NUM_W-1]};
        qbit       = (rem_shift >= {1'b0, divisor});
        quot_shift = {quot_reg, qbit};

        busy_next   = busy_reg;
        done_next   = 1'b0;
        capped_next = capped_reg;
        step_next   = step_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;

        if (start)
        begin
            busy_next   = 1'b1;
            capped_next = 1'b0;
            step_next   = '0;
            num_next    = {dividend, 27'd0};
            rem_next    = '0;
            quot_next   = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = qbit ? PROD_W'(rem_shift - {1'b0, divisor}) : rem_shift[PROD_W-1:0];
            if (!capped_reg)
            begin
                if (quot_shift[QUOT_W] || quot_shift[QUOT_W-1])
                begin
                    quot_next   = {1'b1, {(QUOT_W-1){1'b0}}};
                    capped_next = 1'b1;
                end
                else
                begin
                    quot_next = quot_shift[QUOT_W-1:0];
                end
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        capped_reg <= capped_next;
        step_reg   <= step_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[hw/rtl/gaussian_log_likelihood_accumulator.sv]
// channel   direction  transaction
// s_*       in         one filter: magnitudes, variance, last flag
// m_*       out        one star: saturated log likelihood and filter count
// cfg_*     in         register write, index and data
//
// a used filter passes from acceptance through the product, a normalising
// shift, 30 squaring steps for log2, 37 shift-add steps for the ln 2 scale
// and the restoring divider; a skipped filter goes straight to accumulation
// asynchronous active-low reset clears the fsm, sum, count and output valid
// a new filter is taken while a result waits; a last filter stalls only
// if the previous result has not been taken yet
module gaussian_log_likelihood_accumulator #(
    parameter int MAX_FILTERS = gll_pkg::MAX_FILTERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // observed_mag, model_mag, filter_variance
    input  logic        s_tlast,   // last_filter
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // log_likelihood, filters_used, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gll_pkg::*;

    localparam int LIMIT = (MAX_FILTERS < 127) ? MAX_FILTERS : 127;

    gll_state_t state_reg, state_next;

    // configuration
    logic [SCALE_W-1:0]  scale_reg;
    logic [VAR_W-1:0]    floor_reg;

    // accumulated state
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        used_reg, used_next;

    // item registers
    logic signed [MAG_W-1:0] obs_reg, mdl_reg;
    logic [VAR_W-1:0]        var_reg;
    logic                    last_reg, pass_reg;

    logic [PROD_W-1:0]       p_reg, nrm_reg;
    logic [SQ_W-1:0]         d2_reg;
    logic [5:0]              cnt_reg;
    logic [5:0]              sh_reg;
    logic [31:0]             m_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [LOG_MAG_W-1:0]    mag_reg;
    logic                    neg_reg;
    logic [LN_ACC_W-1:0]     acc_reg;
    logic signed [23:0]      hl_reg;

    // output register
    logic                    out_valid_reg;
    logic [SUM_W-1:0]        out_sum_reg;
    logic [CNT_W-1:0]        out_cnt_reg;

    // control decoded from state
    logic s_accept, div_start, out_free, acc_leave;

    logic [QUOT_W-1:0]       quot;
    logic                    div_done;

    logic signed [MAG_W:0]   diff;
    logic [MAG_W:0]          abs_diff;
    logic [2*MAG_W+1:0]      sq_full;
    logic [63:0]             msq;
    logic [32:0]             msq_sh;
    logic signed [37:0]      lval;
    logic signed [6:0]       exp_s;
    logic [LN_ACC_W:0]       ln_rnd;
    logic [22:0]             hl_mag;
    logic signed [50:0]      term, sum_wide;
    logic signed [SUM_W-1:0] sum_sat;

    gll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (p_reg),
        .dividend (d2_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // arithmetic helpers
    always_comb
    begin
        diff     = (MAG_W+1)'(mdl_reg) - (MAG_W+1)'(obs_reg);
        abs_diff = diff[MAG_W] ? (MAG_W+1)'(-diff) : diff;
        sq_full  = abs_diff * abs_diff;

        msq    = m_reg * m_reg;
        msq_sh = msq[63:31];

        exp_s = 7'sd11 - $signed({1'b0, sh_reg});
        lval  = $signed({exp_s[6], exp_s, 30'd0})
              + $signed({8'd0, frac_reg})
              + $signed({5'd0, LOG2_TWO_PI_Q30});

        ln_rnd = {1'b0, acc_reg} + (LN_ACC_W+1)'(64'd1 << 42);
        hl_mag = ln_rnd[LN_ACC_W:43];

        term     = 51'(hl_reg) + $signed({2'b00, quot});
        sum_wide = 51'(sum_reg) - term;
        if (sum_wide > 51'sh7FFFFFFFFFFF)
            sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
        else if (sum_wide < -51'sh800000000000)
            sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];

        sum_next  = pass_reg ? sum_sat : sum_reg;
        used_next = pass_reg ? CNT_W'(used_reg + 1'b1) : used_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if ((s_tdata[79:48] > floor_reg) && (scale_reg != '0)
                        && (used_reg < CNT_W'(LIMIT)))
                        state_next = ST_MUL;
                    else
                        state_next = ST_ACC;
                end
            end
            ST_MUL:   state_next = ST_NORM;
            ST_NORM:  if (nrm_reg[PROD_W-1]) state_next = ST_SQR;
            ST_SQR:   if (cnt_reg == 6'(LOG_FRAC_BITS - 1)) state_next = ST_LOG;
            ST_LOG:   state_next = ST_LNMUL;
            ST_LNMUL: if (cnt_reg == 6'(LOG_MAG_W - 1)) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_ACC;
            ST_ACC:   if (acc_leave) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        s_accept  = s_tready && s_tvalid;
        div_start = (state_reg == ST_LNMUL) && (cnt_reg == 6'(LOG_MAG_W - 1));
        out_free  = !out_valid_reg || m_tready;
        acc_leave = (state_reg == ST_ACC) && (!last_reg || out_free);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_W'(65536);
            floor_reg     <= '0;
            sum_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_VARIANCE_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_VARIANCE_FLOOR: floor_reg <= cfg_data;
                    default: ;
                endcase
            end
            // a new star result wins over the clearing of the taken one
            if (acc_leave && last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (acc_leave)
            begin
                if (last_reg)
                begin
                    sum_reg  <= '0;
                    used_reg <= '0;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    used_reg <= used_next;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            obs_reg  <= s_tdata[23:0];
            mdl_reg  <= s_tdata[47:24];
            var_reg  <= s_tdata[79:48];
            last_reg <= s_tlast;
            pass_reg <= (s_tdata[79:48] > floor_reg) && (scale_reg != '0)
                        && (used_reg < CNT_W'(LIMIT));
        end
        case (state_reg)
            ST_MUL:
            begin
                p_reg   <= var_reg * scale_reg;
                nrm_reg <= var_reg * scale_reg;
                d2_reg  <= sq_full[SQ_W-1:0];
                sh_reg  <= '0;
            end
            ST_NORM:
            begin
                if (nrm_reg[PROD_W-1])
                begin
                    m_reg    <= nrm_reg[PROD_W-1 -: 32];
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    nrm_reg <= {nrm_reg[PROD_W-2:0], 1'b0};
                    sh_reg  <= sh_reg + 1'b1;
                end
            end
            ST_SQR:
            begin
                m_reg    <= msq_sh[32] ? msq_sh[32:1] : msq_sh[31:0];
                frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], msq_sh[32]};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_LOG:
            begin
                neg_reg <= lval[37];
                mag_reg <= lval[37] ? LOG_MAG_W'(-lval) : lval[LOG_MAG_W-1:0];
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            ST_LNMUL:
            begin
                acc_reg <= {acc_reg[LN_ACC_W-2:0], 1'b0}
                         + (mag_reg[LOG_MAG_W-1] ? LN_ACC_W'(LN2_Q28) : '0);
                mag_reg <= {mag_reg[LOG_MAG_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DIV:
            begin
                hl_reg <= neg_reg ? -$signed({1'b0, hl_mag}) : $signed({1'b0, hl_mag});
            end
            default: ;
        endcase
        if (acc_leave && last_reg)
        begin
            out_sum_reg <= sum_next;
            out_cnt_reg <= used_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_sum_reg};

endmodule
